// ----- rtl/wcg_pkg.sv -----
`timescale 1ns / 1ps

package wcg_pkg;

   localparam int MAX_LENGTH_DEF = 4096;
   localparam int COS_DEPTH_DEF  = 1024;

   localparam int IDX_W   = 12;
   localparam int LEN_W   = 13;
   localparam int KIND_W  = 3;
   localparam int COEF_W  = 18;
   localparam int VAL_W   = 20;
   localparam int COS_W   = 17;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;
   localparam int REQ_DW  = 16;
   localparam int RSP_DW  = 24;
   localparam int DIVG_QW = 30;
   localparam int ACC_W   = 38;
   localparam int PROD_W  = 36;

   localparam logic [2:0] REG_LENGTH = 3'd0;
   localparam logic [2:0] REG_KIND   = 3'd1;
   localparam logic [2:0] REG_A0     = 3'd2;
   localparam logic [2:0] REG_A1     = 3'd3;
   localparam logic [2:0] REG_A2     = 3'd4;
   localparam logic [2:0] REG_A3     = 3'd5;
   localparam logic [2:0] REG_A4     = 3'd6;

   localparam logic [KIND_W-1:0] KIND_COSINE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BARTLETT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TRIANGLE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BHANN    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BOXCAR   = 3'd4;

   localparam logic [31:0] Q16_ONE = 32'd65536;
   localparam logic [31:0] BH_C0   = 32'd40632;
   localparam logic [31:0] BH_C1   = 32'd31457;
   localparam logic [31:0] BH_C2   = 32'd24904;

   localparam logic signed [VAL_W-1:0] VAL_MAX = 20'sh7FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 20'sh80000;

   typedef struct packed {
      logic valid;
      logic oor;
   } side_type;

endpackage

// ----- rtl/wcg_div_cell.sv -----
`timescale 1ns / 1ps

module wcg_div_cell #(
   parameter int DEN_W = 14,
   parameter int QW    = 13
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DEN_W-1:0] den,
   input  logic [DEN_W-1:0] up_rem,
   input  logic [QW-1:0]    up_work,
   output logic [DEN_W-1:0] dn_rem,
   output logic [QW-1:0]    dn_work
);

   logic [DEN_W:0]   trial;
   logic             ge;
   logic [DEN_W-1:0] rem_in;
   logic [QW-1:0]    work_in;
   logic [DEN_W-1:0] rem_ff;
   logic [QW-1:0]    work_ff;

   // one restoring step: shift in the next numerator bit, emit one quotient bit
   always_comb begin
      trial   = {up_rem, up_work[QW-1]};
      ge      = trial >= {1'b0, den};
      rem_in  = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      work_in = {up_work[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_work = work_ff;

endmodule

// ----- rtl/wcg_cos_rom.sv -----
`timescale 1ns / 1ps

module wcg_cos_rom #(
   parameter int COS_TABLE_DEPTH = wcg_pkg::COS_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [$clog2(COS_TABLE_DEPTH+1)-1:0]   rd_addr_a,
   input  logic [$clog2(COS_TABLE_DEPTH+1)-1:0]   rd_addr_b,
   output logic [wcg_pkg::COS_W-1:0]              rd_data_a,
   output logic [wcg_pkg::COS_W-1:0]              rd_data_b
);

   import wcg_pkg::*;

   // (2i-1)*(2i) for the ten series terms, lowest term first
   localparam logic [9:0][8:0] TAYLOR_DIV = {9'd380, 9'd306, 9'd240, 9'd182, 9'd132,
                                             9'd90, 9'd56, 9'd30, 9'd12, 9'd2};

   // quarter-wave cosine, unsigned q16, from a q30 taylor series
   function automatic logic [COS_W-1:0] cos_entry(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] sum;
      x    = (64'd1686629713 * 64'(k) + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      for (int i = 1; i <= 10; i++) begin
         term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[i-1]);
         if (i[0]) sum = sum - signed'(term);
         else sum = sum + signed'(term);
      end
      if (sum <= 0) return '0;
      r = (unsigned'(sum) + 64'd8192) >> 14;
      if (r > 64'(Q16_ONE)) r = 64'(Q16_ONE);
      return COS_W'(r);
   endfunction

   logic [COS_W-1:0] rom [0:COS_TABLE_DEPTH];
   logic [COS_W-1:0] data_a_ff;
   logic [COS_W-1:0] data_b_ff;

   for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [COS_W-1:0] ENTRY = cos_entry(k);
      assign rom[k] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= rom[rd_addr_a];
         data_b_ff <= rom[rd_addr_b];
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

// ----- rtl/window_coefficient_generator.sv -----
`timescale 1ns / 1ps

// window coefficient generator
// req channel: one sample index per request in req_tdata[11:0]. rsp channel: the window
// coefficient in rsp_tdata[19:0] (signed q3.16, saturated) and the out-of-range flag in
// rsp_tuser. csr port: window length, window kind and five cosine-sum weights at byte
// addresses 0, 4, ... 24; write only while no request is in flight.
// a request enters every cycle while req_tready is high. the pipeline is a row of 30
// long-division cells (one quotient bit each) for the ramp division, with the shorter
// phase rows padded to its length, plus three stages ahead of it and seven behind it
// for the cosine lookup, weighting, rounding and saturation.
// reset loads a hann window of 64 points and empties the pipeline; the cosine table is a
// constant rom, so no fill pass follows reset.
// when rsp stalls, the result is held and a second one goes to a skid register; only
// with both full does req_tready fall, and the whole pipeline then stands still.
module window_coefficient_generator #(
   parameter int MAX_LENGTH      = wcg_pkg::MAX_LENGTH_DEF,
   parameter int COS_TABLE_DEPTH = wcg_pkg::COS_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [wcg_pkg::REQ_DW-1:0]  req_tdata,   // [11:0] sample_index
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [wcg_pkg::RSP_DW-1:0]  rsp_tdata,   // [19:0] window_value
   output logic [0:0]                  rsp_tuser,   // [0] index_out_of_range
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wcg_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [wcg_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [wcg_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   import wcg_pkg::*;

   localparam int D        = COS_TABLE_DEPTH;
   localparam int A_W      = $clog2(4 * D + 1);
   localparam int ROM_AW   = $clog2(D + 1);
   localparam int DA_W     = LEN_W + 1;
   localparam int NA_W     = A_W + DA_W;
   localparam int DG_W     = LEN_W + 2;
   localparam int NG_W     = DIVG_QW + DG_W;
   localparam int PAD      = DIVG_QW - A_W;
   localparam int SIDE_LEN = 3 + DIVG_QW + 7;
   localparam int RW       = ACC_W - 16;
   localparam int EIGHT_D  = 8 * D;

   localparam logic [A_W-1:0] QD1 = A_W'(D);
   localparam logic [A_W-1:0] QD2 = A_W'(2 * D);
   localparam logic [A_W-1:0] QD3 = A_W'(3 * D);
   localparam logic [A_W-1:0] QD4 = A_W'(4 * D);

   localparam logic signed [ACC_W-1:0]  BH_BASE    = signed'(ACC_W'(BH_C0) << 16);
   localparam logic signed [COEF_W-1:0] BH_C2_COEF = signed'(COEF_W'(BH_C2));

   function automatic logic [LEN_W-1:0] mod_add(input logic [LEN_W-1:0] x,
                                                 input logic [LEN_W-1:0] y,
                                                 input logic [LEN_W-1:0] mm);
      logic [LEN_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, mm}) s = s - {1'b0, mm};
      return s[LEN_W-1:0];
   endfunction

   // ---------------- configuration registers
   logic [LEN_W-1:0]         len_ff;
   logic [KIND_W-1:0]        kind_ff;
   logic signed [COEF_W-1:0] a0_ff, a1_ff, a2_ff, a3_ff, a4_ff;
   logic                     csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_W'(64);
         kind_ff <= KIND_COSINE;
         a0_ff   <= COEF_W'(32768);
         a1_ff   <= COEF_W'(32768);
         a2_ff   <= '0;
         a3_ff   <= '0;
         a4_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_LENGTH: len_ff <= csr_pwdata[LEN_W-1:0];
            REG_KIND:   kind_ff <= csr_pwdata[KIND_W-1:0];
            REG_A0:     a0_ff <= signed'(csr_pwdata[COEF_W-1:0]);
            REG_A1:     a1_ff <= signed'(csr_pwdata[COEF_W-1:0]);
            REG_A2:     a2_ff <= signed'(csr_pwdata[COEF_W-1:0]);
            REG_A3:     a3_ff <= signed'(csr_pwdata[COEF_W-1:0]);
            REG_A4:     a4_ff <= signed'(csr_pwdata[COEF_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[4:2])
         REG_LENGTH: csr_prdata = CSR_DW'(len_ff);
         REG_KIND:   csr_prdata = CSR_DW'(kind_ff);
         REG_A0:     csr_prdata = CSR_DW'(unsigned'(a0_ff));
         REG_A1:     csr_prdata = CSR_DW'(unsigned'(a1_ff));
         REG_A2:     csr_prdata = CSR_DW'(unsigned'(a2_ff));
         REG_A3:     csr_prdata = CSR_DW'(unsigned'(a3_ff));
         REG_A4:     csr_prdata = CSR_DW'(unsigned'(a4_ff));
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- values derived from configuration
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] m;
   logic [LEN_W:0]   len_p1;
   logic             m_zero;
   logic [DA_W-1:0]  den_a;
   logic [DG_W-1:0]  den_g;

   always_comb begin
      len_eff = ({19'd0, len_ff} > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_ff;
      m       = len_eff - LEN_W'(1);
      len_p1  = {1'b0, len_eff} + (LEN_W + 1)'(1);
      m_zero  = len_eff == LEN_W'(1);
      den_a   = {m, 1'b0};
      den_g   = (kind_ff == KIND_TRIANGLE) ? {len_p1, 1'b0} : {1'b0, m, 1'b0};
   end

   // ---------------- pipeline control and side data
   logic     en;
   logic     accept;
   side_type side_ff [SIDE_LEN];
   side_type side_in;

   logic             skid_valid_ff;
   assign en         = ~skid_valid_ff;
   assign req_tready = en;
   assign accept     = req_tvalid & en;

   // ---------------- stage 1: index checks, distance from centre
   logic [LEN_W-1:0] n13;
   logic [LEN_W-1:0] n2;
   logic [LEN_W-1:0] r1_in, dist_in;
   logic [LEN_W-1:0] r1_s1_ff, dist_s1_ff;

   always_comb begin
      n13           = {1'b0, req_tdata[IDX_W-1:0]};
      n2            = {req_tdata[IDX_W-1:0], 1'b0};
      side_in.valid = accept;
      side_in.oor   = n13 >= len_eff;
      r1_in         = (n13 == m) ? '0 : n13;
      dist_in       = (n2 > m) ? n2 - m : m - n2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_LEN; i++) side_ff[i] <= '0;
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < SIDE_LEN; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // ---------------- stage 2: second harmonic phase
   logic [LEN_W-1:0] r1_s2_ff, r2_s2_ff, dist_s2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r1_s1_ff   <= r1_in;
         dist_s1_ff <= dist_in;
         r1_s2_ff   <= r1_s1_ff;
         r2_s2_ff   <= mod_add(r1_s1_ff, r1_s1_ff, m);
         dist_s2_ff <= dist_s1_ff;
      end
   end

   // ---------------- stage 3: dividends for the cell rows
   logic [LEN_W-1:0] r_h [4];
   logic [NA_W-1:0]  numa_in [4];
   logic [NG_W-1:0]  numg_in;
   logic [DA_W-1:0]  rema_ff [4];
   logic [A_W-1:0]   worka_ff [4];
   logic [DG_W-1:0]  remg_ff;
   logic [DIVG_QW-1:0] workg_ff;

   always_comb begin
      r_h[0] = r1_s2_ff;
      r_h[1] = r2_s2_ff;
      r_h[2] = mod_add(r1_s2_ff, r2_s2_ff, m);
      r_h[3] = mod_add(r2_s2_ff, r2_s2_ff, m);
      for (int h = 0; h < 4; h++) begin
         numa_in[h] = NA_W'(NA_W'(r_h[h]) * NA_W'(EIGHT_D)) + NA_W'(m);
      end
      case (kind_ff)
         KIND_BARTLETT: numg_in = (NG_W'(dist_s2_ff) << 17) + NG_W'(m);
         KIND_TRIANGLE: numg_in = (NG_W'(dist_s2_ff) << 17) + NG_W'(len_p1);
         KIND_BHANN:    numg_in = NG_W'(NG_W'(dist_s2_ff) * NG_W'(BH_C1)) << 16;
         default:       numg_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int h = 0; h < 4; h++) begin
            rema_ff[h]  <= numa_in[h][NA_W-1:A_W];
            worka_ff[h] <= numa_in[h][A_W-1:0];
         end
         remg_ff  <= numg_in[NG_W-1:DIVG_QW];
         workg_ff <= numg_in[DIVG_QW-1:0];
      end
   end

   // ---------------- division cell rows
   logic [DA_W-1:0]    ca_rem  [4][A_W+1];
   logic [A_W-1:0]     ca_work [4][A_W+1];
   logic [DG_W-1:0]    cg_rem  [DIVG_QW+1];
   logic [DIVG_QW-1:0] cg_work [DIVG_QW+1];

   for (genvar h = 0; h < 4; h++) begin : g_lane
      assign ca_rem[h][0]  = rema_ff[h];
      assign ca_work[h][0] = worka_ff[h];
      for (genvar c = 0; c < A_W; c++) begin : g_cell
         wcg_div_cell #(
            .DEN_W (DA_W),
            .QW    (A_W)
         ) u_cell (
            .clock   (clock),
            .en      (en),
            .den     (den_a),
            .up_rem  (ca_rem[h][c]),
            .up_work (ca_work[h][c]),
            .dn_rem  (ca_rem[h][c+1]),
            .dn_work (ca_work[h][c+1])
         );
      end
   end

   assign cg_rem[0]  = remg_ff;
   assign cg_work[0] = workg_ff;
   for (genvar c = 0; c < DIVG_QW; c++) begin : g_gcell
      wcg_div_cell #(
         .DEN_W (DG_W),
         .QW    (DIVG_QW)
      ) u_cell (
         .clock   (clock),
         .en      (en),
         .den     (den_g),
         .up_rem  (cg_rem[c]),
         .up_work (cg_work[c]),
         .dn_rem  (cg_rem[c+1]),
         .dn_work (cg_work[c+1])
      );
   end

   // phase rows are shorter: line them up with the ramp row
   logic [A_W-1:0] apad_ff [4][PAD];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int h = 0; h < 4; h++) begin
            apad_ff[h][0] <= ca_work[h][A_W];
            for (int i = 1; i < PAD; i++) apad_ff[h][i] <= apad_ff[h][i-1];
         end
      end
   end

   // ---------------- post 1: quarter-wave folding
   logic [A_W-1:0]    aw [4];
   logic [A_W-1:0]    idx_full [4];
   logic              neg_in [4];
   logic [ROM_AW-1:0] idx_ff [4];
   logic              neg_p1_ff [4];
   logic              neg_p2_ff [4];
   logic [DIVG_QW-1:0] qg_ff [6];

   always_comb begin
      for (int h = 0; h < 4; h++) begin
         aw[h] = (apad_ff[h][PAD-1] >= QD4) ? apad_ff[h][PAD-1] - QD4 : apad_ff[h][PAD-1];
         if (aw[h] < QD1) begin
            idx_full[h] = aw[h];
            neg_in[h]   = 1'b0;
         end else if (aw[h] < QD2) begin
            idx_full[h] = QD2 - aw[h];
            neg_in[h]   = 1'b1;
         end else if (aw[h] < QD3) begin
            idx_full[h] = aw[h] - QD2;
            neg_in[h]   = 1'b1;
         end else begin
            idx_full[h] = QD4 - aw[h];
            neg_in[h]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int h = 0; h < 4; h++) begin
            idx_ff[h]    <= idx_full[h][ROM_AW-1:0];
            neg_p1_ff[h] <= neg_in[h];
            neg_p2_ff[h] <= neg_p1_ff[h];
         end
         qg_ff[0] <= cg_work[DIVG_QW];
         for (int i = 1; i < 6; i++) qg_ff[i] <= qg_ff[i-1];
      end
   end

   // ---------------- post 2: table read
   logic [COS_W-1:0] cos_rd [4];

   wcg_cos_rom #(
      .COS_TABLE_DEPTH (D)
   ) u_rom_lo (
      .clock     (clock),
      .en        (en),
      .rd_addr_a (idx_ff[0]),
      .rd_addr_b (idx_ff[1]),
      .rd_data_a (cos_rd[0]),
      .rd_data_b (cos_rd[1])
   );

   wcg_cos_rom #(
      .COS_TABLE_DEPTH (D)
   ) u_rom_hi (
      .clock     (clock),
      .en        (en),
      .rd_addr_a (idx_ff[2]),
      .rd_addr_b (idx_ff[3]),
      .rd_data_a (cos_rd[2]),
      .rd_data_b (cos_rd[3])
   );

   // ---------------- post 3, 4: signed cosine, weighting
   logic signed [COEF_W-1:0] cs_ff [4];
   logic signed [COEF_W-1:0] wt [4];
   logic signed [PROD_W-1:0] prod_ff [4];

   always_comb begin
      wt[0] = (kind_ff == KIND_BHANN) ? BH_C2_COEF : a1_ff;
      wt[1] = a2_ff;
      wt[2] = a3_ff;
      wt[3] = a4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int h = 0; h < 4; h++) begin
            cs_ff[h]   <= neg_p2_ff[h] ? -signed'({1'b0, cos_rd[h]})
                                       : signed'({1'b0, cos_rd[h]});
            prod_ff[h] <= wt[h] * cs_ff[h];
         end
      end
   end

   // ---------------- post 5, 6: sum and rounding
   logic                    k3;
   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W-1:0] sum_a_ff, sum_b_ff;
   logic signed [ACC_W-1:0] acc;
   logic signed [RW-1:0]    rnd_ff;

   always_comb begin
      k3   = kind_ff == KIND_BHANN;
      base = k3 ? BH_BASE - signed'(ACC_W'(qg_ff[3]))
                : signed'(ACC_W'(a0_ff) << 16);
      acc  = sum_a_ff + sum_b_ff + ACC_W'(32768);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_a_ff <= base - ACC_W'(prod_ff[0]) + (k3 ? '0 : ACC_W'(prod_ff[1]));
         sum_b_ff <= k3 ? '0 : ACC_W'(prod_ff[3]) - ACC_W'(prod_ff[2]);
         rnd_ff   <= RW'(acc >>> 16);
      end
   end

   // ---------------- post 7: kind select and saturation
   logic signed [VAL_W-1:0] sat;
   logic [VAL_W-1:0]        ramp;
   logic [VAL_W-1:0]        val_in;
   logic [VAL_W-1:0]        res_val_ff;
   logic                    res_oor_ff;

   always_comb begin
      if (rnd_ff > RW'(VAL_MAX)) sat = VAL_MAX;
      else if (rnd_ff < RW'(VAL_MIN)) sat = VAL_MIN;
      else sat = rnd_ff[VAL_W-1:0];
      ramp = VAL_W'(Q16_ONE - 32'(qg_ff[5]));
      if (side_ff[SIDE_LEN-2].oor || kind_ff > KIND_BOXCAR) begin
         val_in = '0;
      end else if (m_zero) begin
         val_in = VAL_W'(Q16_ONE);
      end else begin
         case (kind_ff) inside
            KIND_COSINE, KIND_BHANN:      val_in = sat;
            KIND_BARTLETT, KIND_TRIANGLE: val_in = ramp;
            default:                      val_in = VAL_W'(Q16_ONE);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_val_ff <= val_in;
         res_oor_ff <= side_ff[SIDE_LEN-2].oor;
      end
   end

   // ---------------- output register and skid
   logic             push;
   logic             out_valid_ff;
   logic [VAL_W-1:0] out_val_ff, skid_val_ff;
   logic             out_oor_ff, skid_oor_ff;

   assign push = en & side_ff[SIDE_LEN-1].valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_val_ff    <= skid_val_ff;
            out_oor_ff    <= skid_oor_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || rsp_tready) begin
            out_val_ff   <= res_val_ff;
            out_oor_ff   <= res_oor_ff;
            out_valid_ff <= 1'b1;
         end else begin
            skid_val_ff   <= res_val_ff;
            skid_oor_ff   <= res_oor_ff;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DW'(out_val_ff);
   assign rsp_tuser  = out_oor_ff;

endmodule

// ----- rtl/wcg_checker.sv -----
`timescale 1ns / 1ps

module wcg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [wcg_pkg::RSP_DW-1:0] rsp_tdata,
   input logic [0:0]                 rsp_tuser
);

   import wcg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("out-of-range response with non-zero value");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side stalled with no response waiting");

endmodule

bind window_coefficient_generator wcg_checker u_wcg_checker (.*);
